// ===== src/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent check on the block clock, off while in reset.
`define JAC_ASSERT(label, prop, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);

// Implication checked on the same edge.
`define JAC_ASSERT_IMP(label, pre, post, msg) \
    `JAC_ASSERT(label, (pre) |-> (post), msg)

`endif

// ===== src/jac_pkg.sv =====
package jac_pkg;

    localparam int SAMPLE_W = 16;
    localparam int CAL_W    = 12;
    localparam int POS_W    = 13;
    localparam int SCALE_SH = 11;
    localparam int QUO_W    = 13;
    localparam int REM_W    = CAL_W + SCALE_SH + 1;
    localparam int X_W      = QUO_W + 2;
    localparam int ADDR_W   = 3;

    localparam logic [ADDR_W-1:0] REG_CAL_MIN  = 3'd0;
    localparam logic [ADDR_W-1:0] REG_CAL_MID  = 3'd1;
    localparam logic [ADDR_W-1:0] REG_CAL_MAX  = 3'd2;
    localparam logic [ADDR_W-1:0] REG_INVERT   = 3'd3;
    localparam logic [ADDR_W-1:0] REG_POT_MODE = 3'd4;

    localparam logic [CAL_W-1:0] CAL_MID_RST = 12'd2048;
    localparam logic [POS_W-1:0] POS_ONE     = 13'd2048;
    localparam logic [POS_W-1:0] POS_NEG_ONE = 13'h1800;
    localparam logic [POS_W-1:0] POS_HALF    = 13'd2048;
    localparam logic [X_W-1:0]   X_MID       = 15'd2048;
    localparam logic [X_W-1:0]   X_TOP       = 15'd4095;

    typedef struct packed {
        logic [CAL_W-1:0] cal_min;
        logic [CAL_W-1:0] cal_mid;
        logic [CAL_W-1:0] cal_max;
        logic             invert;
        logic             pot_mode;
    } jac_cfg_t;

    typedef struct packed {
        logic             bypass;
        logic             ok;
        logic [POS_W-1:0] pos;
        logic             neg;
        logic             hi;
        logic             ovf;
        logic [REM_W-1:0] rem;
        logic [CAL_W-1:0] den;
        logic [QUO_W-1:0] quo;
    } jac_item_t;

endpackage

// ===== src/jac_front.sv =====
`include "assert_macros.svh"

module jac_front (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  jac_pkg::jac_cfg_t              cfg,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [jac_pkg::SAMPLE_W-1:0]   in_sample,
    output logic                           out_valid,
    input  logic                           out_ready,
    output jac_pkg::jac_item_t             out_item
);

    logic               valid_reg, valid_next;
    jac_pkg::jac_item_t item_reg, item_next;

    logic [jac_pkg::CAL_W-1:0] s12;
    logic                      bad;
    logic                      hi;
    logic [jac_pkg::CAL_W:0]   num, den, num_neg, den_neg;
    logic [jac_pkg::CAL_W-1:0] nmag, dmag;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb begin
        s12     = in_sample[jac_pkg::CAL_W-1:0];
        bad     = |in_sample[jac_pkg::SAMPLE_W-1:jac_pkg::CAL_W];
        hi      = s12 >= cfg.cal_mid;
        num     = hi ? ({1'b0, s12} - {1'b0, cfg.cal_mid})
                     : ({1'b0, s12} - {1'b0, cfg.cal_min});
        den     = hi ? ({1'b0, cfg.cal_max} - {1'b0, cfg.cal_mid})
                     : ({1'b0, cfg.cal_mid} - {1'b0, cfg.cal_min});
        num_neg = -num;
        den_neg = -den;
        nmag    = num[jac_pkg::CAL_W] ? num_neg[jac_pkg::CAL_W-1:0] : num[jac_pkg::CAL_W-1:0];
        dmag    = den[jac_pkg::CAL_W] ? den_neg[jac_pkg::CAL_W-1:0] : den[jac_pkg::CAL_W-1:0];

        item_next = '0;
        if (cfg.pot_mode) begin
            item_next.bypass = 1'b1;
            item_next.ok     = 1'b1;
            item_next.pos    = bad ? jac_pkg::POS_ONE : ({1'b0, s12} - jac_pkg::POS_HALF);
        end else if (bad) begin
            item_next.bypass = 1'b1;
        end else if (cfg.cal_max == '0) begin
            item_next.bypass = 1'b1;
            item_next.ok     = 1'b1;
            item_next.pos    = {1'b0, s12} - jac_pkg::POS_HALF;
        end else if (den == '0) begin
            item_next.bypass = 1'b1;
        end else begin
            item_next.ok  = 1'b1;
            item_next.neg = num[jac_pkg::CAL_W] ^ den[jac_pkg::CAL_W];
            item_next.hi  = hi;
            item_next.ovf = (nmag >> (jac_pkg::QUO_W - jac_pkg::SCALE_SH)) >= dmag;
            item_next.rem = {1'b0, nmag, {jac_pkg::SCALE_SH{1'b0}}};
            item_next.den = dmag;
        end

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    `JAC_ASSERT_IMP(a_front_den_nonzero, valid_reg && !item_reg.bypass,
        item_reg.den != '0, "divide item with zero divisor")

endmodule

// ===== src/jac_div_cell.sv =====
`include "assert_macros.svh"

module jac_div_cell #(
    parameter int BIT = 0
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               in_valid,
    output logic               in_ready,
    input  jac_pkg::jac_item_t in_item,
    output logic               out_valid,
    input  logic               out_ready,
    output jac_pkg::jac_item_t out_item
);

    logic               valid_reg, valid_next;
    jac_pkg::jac_item_t item_reg, item_next;

    logic [jac_pkg::REM_W-1:0] dsh;
    logic [jac_pkg::REM_W:0]   diff;
    logic [jac_pkg::REM_W-1:0] dsh_reg;

    assign in_ready  = !valid_reg || out_ready;
    assign out_valid = valid_reg;
    assign out_item  = item_reg;
    assign dsh_reg   = jac_pkg::REM_W'(item_reg.den) << BIT;

    always_comb begin
        dsh       = jac_pkg::REM_W'(in_item.den) << BIT;
        diff      = {1'b0, in_item.rem} - {1'b0, dsh};
        item_next = in_item;
        if (!diff[jac_pkg::REM_W]) begin
            item_next.rem      = diff[jac_pkg::REM_W-1:0];
            item_next.quo[BIT] = 1'b1;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            item_reg <= item_next;
        end
    end

    `JAC_ASSERT_IMP(a_cell_rem_bound, valid_reg && !item_reg.bypass && !item_reg.ovf,
        item_reg.rem < dsh_reg, "remainder not reduced below shifted divisor")

endmodule

// ===== src/jac_back.sv =====
`include "assert_macros.svh"

module jac_back (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        invert,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  jac_pkg::jac_item_t          in_item,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [jac_pkg::POS_W-1:0]   out_position,
    output logic                        out_ok
);

    logic                      valid_reg, valid_next;
    logic [jac_pkg::POS_W-1:0] pos_reg, pos_next;
    logic                      ok_reg;

    logic [jac_pkg::X_W-1:0]   quo_x, sq, x;
    logic [jac_pkg::POS_W-1:0] pos;

    assign in_ready     = !valid_reg || out_ready;
    assign out_valid    = valid_reg;
    assign out_position = pos_reg;
    assign out_ok       = ok_reg;

    always_comb begin
        quo_x = jac_pkg::X_W'(in_item.quo);
        sq    = in_item.neg ? -quo_x : quo_x;
        x     = sq + (in_item.hi ? jac_pkg::X_MID : '0);

        if (in_item.bypass) begin
            pos = in_item.pos;
        end else if (in_item.ovf) begin
            pos = in_item.neg ? jac_pkg::POS_NEG_ONE : jac_pkg::POS_ONE;
        end else if (x[jac_pkg::X_W-1]) begin
            pos = jac_pkg::POS_NEG_ONE;
        end else if (x > jac_pkg::X_TOP) begin
            pos = jac_pkg::POS_ONE;
        end else begin
            pos = x[jac_pkg::POS_W-1:0] - jac_pkg::POS_HALF;
        end

        if (!in_item.ok) begin
            pos_next = '0;
        end else if (invert) begin
            pos_next = -pos;
        end else begin
            pos_next = pos;
        end

        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            pos_reg <= pos_next;
            ok_reg  <= in_item.ok;
        end
    end

    `JAC_ASSERT_IMP(a_back_bad_zero, valid_reg && !ok_reg,
        pos_reg == '0, "invalid result with nonzero position")
    `JAC_ASSERT_IMP(a_back_range, valid_reg && ok_reg,
        ($signed(pos_reg) >= -13'sd2048) && ($signed(pos_reg) <= 13'sd2048),
        "position outside -1..+1")

endmodule

// ===== src/joystick_axis_calibration.sv =====
// Three-point calibration of one raw 12-bit joystick or potentiometer sample
// to a Q1.11 position (-2048 = -1.0, +2048 = +1.0) plus a valid flag. One beat
// is taken per clock unless a stalled output has filled the pipeline. Each sample
// passes through one decode stage, a row of 13 restoring-divider cells that each
// settle one quotient bit, and the output register. The per-cell handshake lets
// beats close up behind a stalled output. Calibration registers are written
// through cfg_wr_en/cfg_addr/cfg_wdata and must only be changed while no beat is
// in flight.
module joystick_axis_calibration (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [jac_pkg::ADDR_W-1:0]     cfg_addr,
    input  logic [jac_pkg::CAL_W-1:0]      cfg_wdata,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic [jac_pkg::SAMPLE_W-1:0]   s_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [jac_pkg::POS_W-1:0] m_position,
    output logic                           m_valid_res
);

    localparam int NCELL = jac_pkg::QUO_W;

    jac_pkg::jac_cfg_t  cfg_reg, cfg_next;

    logic               c_valid [NCELL+1];
    logic               c_ready [NCELL+1];
    jac_pkg::jac_item_t c_item  [NCELL+1];
    logic [jac_pkg::POS_W-1:0] position;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_wr_en) begin
            case (cfg_addr)
                jac_pkg::REG_CAL_MIN:  cfg_next.cal_min  = cfg_wdata;
                jac_pkg::REG_CAL_MID:  cfg_next.cal_mid  = cfg_wdata;
                jac_pkg::REG_CAL_MAX:  cfg_next.cal_max  = cfg_wdata;
                jac_pkg::REG_INVERT:   cfg_next.invert   = cfg_wdata[0];
                jac_pkg::REG_POT_MODE: cfg_next.pot_mode = cfg_wdata[0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.cal_min  <= '0;
            cfg_reg.cal_mid  <= jac_pkg::CAL_MID_RST;
            cfg_reg.cal_max  <= '0;
            cfg_reg.invert   <= 1'b0;
            cfg_reg.pot_mode <= 1'b0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    jac_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg       (cfg_reg),
        .in_valid  (s_valid),
        .in_ready  (s_ready),
        .in_sample (s_sample),
        .out_valid (c_valid[0]),
        .out_ready (c_ready[0]),
        .out_item  (c_item[0])
    );

    for (genvar i = 0; i < NCELL; i++) begin : g_cell
        jac_div_cell #(
            .BIT (NCELL - 1 - i)
        ) u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (c_valid[i]),
            .in_ready  (c_ready[i]),
            .in_item   (c_item[i]),
            .out_valid (c_valid[i+1]),
            .out_ready (c_ready[i+1]),
            .out_item  (c_item[i+1])
        );
    end

    jac_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .invert       (cfg_reg.invert),
        .in_valid     (c_valid[NCELL]),
        .in_ready     (c_ready[NCELL]),
        .in_item      (c_item[NCELL]),
        .out_valid    (m_valid),
        .out_ready    (m_ready),
        .out_position (position),
        .out_ok       (m_valid_res)
    );

    assign m_position = $signed(position);

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps

module tb_top;

    localparam int Q_ONE          = 2048;
    localparam int X_MAX          = 4095;
    localparam int BAD_READ       = 4096;
    localparam int DRAIN_CYCLES   = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 13;

    typedef struct packed {
        logic signed [jac_pkg::POS_W-1:0] position;
        logic                             valid_res;
    } axis_result_t;

    logic                             aclk        = 1'b0;
    logic                             aresetn     = 1'b0;
    logic                             cfg_wr_en   = 1'b0;
    logic [jac_pkg::ADDR_W-1:0]       cfg_addr    = '0;
    logic [jac_pkg::CAL_W-1:0]        cfg_wdata   = '0;
    logic                             s_valid     = 1'b0;
    logic                             s_ready;
    logic [jac_pkg::SAMPLE_W-1:0]     s_sample    = '0;
    logic                             m_valid;
    logic                             m_ready     = 1'b0;
    logic signed [jac_pkg::POS_W-1:0] m_position;
    logic                             m_valid_res;

    jac_pkg::jac_cfg_t                cfg_model;
    logic [jac_pkg::SAMPLE_W-1:0]     raw_samples[$];
    axis_result_t                     expected_positions[$];
    axis_result_t                     want;

    int                      burst_left  = 1;
    int                      gap_left    = 0;
    logic [15:0]             ready_pat   = 16'hFFFF;
    int                      pat_age     = 0;
    int                      idle_cycles = 0;
    int                      mismatches  = 0;
    int                      results_checked = 0;
    int                      settings_run = 0;

    joystick_axis_calibration i_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wdata   (cfg_wdata),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_sample    (s_sample),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_position  (m_position),
        .m_valid_res (m_valid_res)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    function automatic int clamp_to_unit(input int x);
        if (x < 0) begin
            return -Q_ONE;
        end
        if (x > X_MAX) begin
            return Q_ONE;
        end
        return x - Q_ONE;
    endfunction

    function automatic axis_result_t calibrate(input logic [jac_pkg::SAMPLE_W-1:0] raw,
                                               input jac_pkg::jac_cfg_t c);
        int           s;
        int           mn;
        int           md;
        int           mx;
        int           num;
        int           den;
        int           x;
        int           p;
        bit           ok;
        axis_result_t r;
        s  = int'(raw);
        mn = int'(c.cal_min);
        md = int'(c.cal_mid);
        mx = int'(c.cal_max);
        ok = 1'b1;
        p  = 0;
        if (c.pot_mode) begin
            p = clamp_to_unit(s);
        end else if (s >= BAD_READ) begin
            ok = 1'b0;
        end else if (mx == 0) begin
            p = clamp_to_unit(s);
        end else begin
            if (s >= md) begin
                num = (s - md) * Q_ONE;
                den = mx - md;
            end else begin
                num = (s - mn) * Q_ONE;
                den = md - mn;
            end
            if (den == 0) begin
                ok = 1'b0;
            end else begin
                x = num / den;
                if (s >= md) begin
                    x += Q_ONE;
                end
                p = clamp_to_unit(x);
            end
        end
        if (!ok) begin
            p = 0;
        end else if (c.invert) begin
            p = -p;
        end
        r.position  = p[jac_pkg::POS_W-1:0];
        r.valid_res = ok;
        return r;
    endfunction

    function automatic jac_pkg::jac_cfg_t make_cfg(input int mn, input int md, input int mx,
                                                   input bit inv, input bit pot);
        jac_pkg::jac_cfg_t c;
        c.cal_min  = mn[jac_pkg::CAL_W-1:0];
        c.cal_mid  = md[jac_pkg::CAL_W-1:0];
        c.cal_max  = mx[jac_pkg::CAL_W-1:0];
        c.invert   = inv;
        c.pot_mode = pot;
        return c;
    endfunction

    function automatic int pick_extreme();
        return ($urandom_range(0, 1) == 0) ? 0 : X_MAX;
    endfunction

    function automatic jac_pkg::jac_cfg_t random_cfg();
        int mn;
        int md;
        int mx;
        int kind;
        kind = $urandom_range(0, 15);
        mn = $urandom_range(0, 600);
        md = $urandom_range(1600, 2500);
        mx = $urandom_range(3400, X_MAX);
        if (kind < 3) begin
            mn = $urandom_range(0, X_MAX);
            md = $urandom_range(0, X_MAX);
            mx = $urandom_range(0, X_MAX);
        end else if (kind < 5) begin
            mn = pick_extreme();
            md = pick_extreme();
            mx = pick_extreme();
        end else if (kind == 5) begin
            md = mn;
        end else if (kind == 6) begin
            md = mx;
        end else if (kind == 7) begin
            mx = 0;
        end else if (kind == 8) begin
            mn = $urandom_range(3400, X_MAX);
            mx = $urandom_range(1, 600);
        end
        return make_cfg(mn, md, mx, 1'($urandom_range(0, 1)), $urandom_range(0, 4) == 0);
    endfunction

    function automatic logic [jac_pkg::SAMPLE_W-1:0] random_sample(input jac_pkg::jac_cfg_t c);
        int kind;
        int p;
        kind = $urandom_range(0, 19);
        if (kind < 12) begin
            return jac_pkg::SAMPLE_W'($urandom_range(0, X_MAX));
        end else if (kind < 15) begin
            case ($urandom_range(0, 2))
                0: p = int'(c.cal_min);
                1: p = int'(c.cal_mid);
                default: p = int'(c.cal_max);
            endcase
            p = p + int'($urandom_range(0, 6)) - 3;
            if (p < 0) begin
                p = 0;
            end else if (p > X_MAX) begin
                p = X_MAX;
            end
            return p[jac_pkg::SAMPLE_W-1:0];
        end else if (kind < 17) begin
            case ($urandom_range(0, 3))
                0: return '0;
                1: return jac_pkg::SAMPLE_W'(X_MAX);
                2: return jac_pkg::SAMPLE_W'(BAD_READ);
                default: return {jac_pkg::SAMPLE_W{1'b1}};
            endcase
        end
        return jac_pkg::SAMPLE_W'($urandom_range(0, 16'hFFFF));
    endfunction

    task automatic apply_cfg(input jac_pkg::jac_cfg_t c);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= jac_pkg::REG_CAL_MIN;
        cfg_wdata <= c.cal_min;
        @(posedge aclk);
        cfg_addr  <= jac_pkg::REG_CAL_MID;
        cfg_wdata <= c.cal_mid;
        @(posedge aclk);
        cfg_addr  <= jac_pkg::REG_CAL_MAX;
        cfg_wdata <= c.cal_max;
        @(posedge aclk);
        cfg_addr  <= jac_pkg::REG_INVERT;
        cfg_wdata <= {{(jac_pkg::CAL_W-1){1'b0}}, c.invert};
        @(posedge aclk);
        cfg_addr  <= jac_pkg::REG_POT_MODE;
        cfg_wdata <= {{(jac_pkg::CAL_W-1){1'b0}}, c.pot_mode};
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cfg_model = c;
        settings_run++;
    endtask

    task automatic drain();
        @(posedge aclk);
        while (raw_samples.size() != 0 || s_valid || expected_positions.size() != 0) begin
            @(posedge aclk);
        end
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_positions.push_back(calibrate(s_sample, cfg_model));
            end
            if (!s_valid || s_ready) begin
                if (gap_left != 0) begin
                    gap_left <= gap_left - 1;
                    s_valid  <= 1'b0;
                end else if (raw_samples.size() != 0) begin
                    s_valid  <= 1'b1;
                    s_sample <= raw_samples.pop_front();
                    if (burst_left <= 1) begin
                        burst_left <= $urandom_range(1, 24);
                        gap_left   <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // receiver: rotating stall pattern, refreshed each time pat_age wraps
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_positions.size() == 0) begin
                    $error("unexpected beat: position %0d, valid_res %0b", m_position,
                           m_valid_res);
                    mismatches++;
                end else begin
                    want = expected_positions.pop_front();
                    results_checked++;
                    if (m_position !== want.position) begin
                        $error("position: expected %0d, got %0d", $signed(want.position),
                               m_position);
                        mismatches++;
                    end
                    if (m_valid_res !== want.valid_res) begin
                        $error("valid_res: expected %0b, got %0b", want.valid_res, m_valid_res);
                        mismatches++;
                    end
                end
            end
            m_ready <= ready_pat[0];
            if (pat_age == 63) begin
                pat_age   <= 0;
                ready_pat <= ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                         : (16'($urandom_range(0, 16'hFFFF)) | 16'h1);
            end else begin
                pat_age   <= pat_age + 1;
                ready_pat <= {ready_pat[0], ready_pat[15:1]};
            end
        end
    end

    always @(posedge aclk) begin
        if (!aresetn || cfg_wr_en || (s_valid && s_ready) || (m_valid && m_ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        jac_pkg::jac_cfg_t c;
        int                n;
        cfg_model = make_cfg(0, int'(jac_pkg::CAL_MID_RST), 0, 1'b0, 1'b0);
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // reset calibration: uncalibrated stick, bad reads
        raw_samples = '{16'd0, 16'd2048, 16'd4095, 16'd4096, 16'hFFFF};
        drain();

        apply_cfg(make_cfg(100, 2000, 3900, 1'b0, 1'b0));
        raw_samples = '{16'd50, 16'd100, 16'd1999, 16'd2000, 16'd3900, 16'd4000};
        drain();

        // zero divisor on both segments
        apply_cfg(make_cfg(1000, 1000, 1000, 1'b0, 1'b0));
        raw_samples = '{16'd999, 16'd1000};
        drain();

        // reversed calibration, inverted
        apply_cfg(make_cfg(4000, 2048, 100, 1'b1, 1'b0));
        raw_samples = '{16'd0, 16'd3000, 16'd4095};
        drain();

        apply_cfg(make_cfg(0, 2048, 0, 1'b1, 1'b1));
        raw_samples = '{16'd0, 16'd2048, 16'd4095, 16'hFFFF};
        drain();

        apply_cfg(make_cfg(0, 0, 4095, 1'b0, 1'b0));
        raw_samples = '{16'd0, 16'd4095};
        drain();

        apply_cfg(make_cfg(4095, 4095, 4095, 1'b0, 1'b0));
        raw_samples = '{16'd4094, 16'd4095};
        drain();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            c = random_cfg();
            apply_cfg(c);
            n = $urandom_range(40, 68);
            for (int i = 0; i < n; i++) begin
                raw_samples.push_back(random_sample(c));
            end
            drain();
        end

        $display("Checked %0d results across %0d calibration settings", results_checked,
                 settings_run + 1);
        $display("(stick and pot modes, invert, zero and reversed divisors, bad reads).");
        if (mismatches == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
+incdir+src
src/jac_pkg.sv
src/jac_front.sv
src/jac_div_cell.sv
src/jac_back.sv
src/joystick_axis_calibration.sv
tb/tb_top.sv
